@@ src/rvx_pkg.sv @@
// Shared types, constants and helpers for the RV64IM execute stage.
// Used by every module under src; depends on nothing.
`default_nettype none
package rvx_pkg;

  localparam int XLEN = 64;
  localparam int PCW = 62;
  localparam int NUM_CELLS = XLEN;

  typedef enum logic [4:0] {
    CMD_ADD    = 5'd0,
    CMD_SUB    = 5'd1,
    CMD_MUL    = 5'd2,
    CMD_MULH   = 5'd3,
    CMD_DIV    = 5'd4,
    CMD_REM    = 5'd5,
    CMD_SLL    = 5'd6,
    CMD_SRL    = 5'd7,
    CMD_SRA    = 5'd8,
    CMD_AND    = 5'd9,
    CMD_OR     = 5'd10,
    CMD_XOR    = 5'd11,
    CMD_SLT    = 5'd12,
    CMD_ADDIW  = 5'd13,
    CMD_BEQ    = 5'd14,
    CMD_BNE    = 5'd15,
    CMD_BLT    = 5'd16,
    CMD_BGE    = 5'd17,
    CMD_PASS_A = 5'd18,
    CMD_PASS_B = 5'd19,
    CMD_ADDW   = 5'd20,
    CMD_SUBW   = 5'd21,
    CMD_MULW   = 5'd22,
    CMD_DIVW   = 5'd23,
    CMD_SLLIW  = 5'd24
  } cmd_t;

  // Which value the finishing stage delivers.
  typedef enum logic [2:0] {
    SEL_EARLY  = 3'd0,
    SEL_MUL_LO = 3'd1,
    SEL_MUL_HI = 3'd2,
    SEL_MULW   = 3'd3,
    SEL_DIV    = 3'd4,
    SEL_REM    = 3'd5,
    SEL_DIVW   = 3'd6
  } sel_t;

  // Everything one transaction carries along the chain of cells.
  typedef struct packed {
    logic [XLEN-1:0]   early;
    logic              taken;
    logic [PCW-1:0]    target;
    sel_t              sel;
    logic              neg_p;
    logic              neg_q;
    logic              neg_r;
    logic              div_zero;
    logic [2*XLEN-1:0] prod;
    logic [XLEN-1:0]   mcand;
    logic [XLEN-1:0]   drem;
    logic [XLEN-1:0]   dquo;
    logic [XLEN-1:0]   dsor;
  } cell_t;

  function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
    return {{(XLEN-32){v[31]}}, v[31:0]};
  endfunction

  function automatic logic [XLEN-1:0] mag(input logic [XLEN-1:0] v);
    return v[XLEN-1] ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

@@ src/rvx_prep.sv @@
// Front stage: decodes the operation, computes the ALU, branch and link results
// and loads the multiply and divide state. Depends on rvx_pkg.
`default_nettype none
module rvx_prep (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [4:0]                   command,
  input  wire logic [rvx_pkg::XLEN-1:0]     operand_a,
  input  wire logic [rvx_pkg::XLEN-1:0]     operand_b,
  input  wire logic [rvx_pkg::XLEN-1:0]     compare_value,
  input  wire logic [rvx_pkg::PCW-1:0]      pc_word,
  input  wire logic                         link_select,
  output logic                              valid_r,
  output rvx_pkg::cell_t                    data_r
);

  rvx_pkg::cell_t data_nxt;
  logic [rvx_pkg::XLEN-1:0] alu;
  logic [rvx_pkg::XLEN-1:0] da;
  logic [rvx_pkg::XLEN-1:0] db;
  logic [5:0] sh;
  logic lt_b;
  logic lt_cv;

  // Decode and ALU and branch arithmetic.
  always_comb begin
    sh = operand_b[5:0];
    lt_b = $signed(operand_a) < $signed(operand_b);
    lt_cv = $signed(operand_a) < $signed(compare_value);
    alu = '0;
    data_nxt = '0;
    data_nxt.sel = rvx_pkg::SEL_EARLY;
    case (rvx_pkg::cmd_t'(command))
      rvx_pkg::CMD_ADD:    alu = operand_a + operand_b;
      rvx_pkg::CMD_SUB:    alu = operand_a - operand_b;
      rvx_pkg::CMD_MUL:    data_nxt.sel = rvx_pkg::SEL_MUL_LO;
      rvx_pkg::CMD_MULH:   data_nxt.sel = rvx_pkg::SEL_MUL_HI;
      rvx_pkg::CMD_DIV:    data_nxt.sel = rvx_pkg::SEL_DIV;
      rvx_pkg::CMD_REM:    data_nxt.sel = rvx_pkg::SEL_REM;
      rvx_pkg::CMD_SLL:    alu = operand_a << sh;
      rvx_pkg::CMD_SRL:    alu = operand_a >> sh;
      rvx_pkg::CMD_SRA:    alu = $unsigned($signed(operand_a) >>> sh);
      rvx_pkg::CMD_AND:    alu = operand_a & operand_b;
      rvx_pkg::CMD_OR:     alu = operand_a | operand_b;
      rvx_pkg::CMD_XOR:    alu = operand_a ^ operand_b;
      rvx_pkg::CMD_SLT:    alu = {{(rvx_pkg::XLEN-1){1'b0}}, lt_b};
      rvx_pkg::CMD_ADDIW:  alu = rvx_pkg::sext32(operand_a + operand_b);
      rvx_pkg::CMD_BEQ:    data_nxt.taken = (operand_a == compare_value);
      rvx_pkg::CMD_BNE:    data_nxt.taken = (operand_a != compare_value);
      rvx_pkg::CMD_BLT:    data_nxt.taken = lt_cv;
      rvx_pkg::CMD_BGE:    data_nxt.taken = !lt_cv;
      rvx_pkg::CMD_PASS_A: alu = operand_a;
      rvx_pkg::CMD_PASS_B: alu = operand_b;
      rvx_pkg::CMD_ADDW:   alu = rvx_pkg::sext32(operand_a + operand_b);
      rvx_pkg::CMD_SUBW:   alu = rvx_pkg::sext32(operand_a - operand_b);
      rvx_pkg::CMD_MULW:   data_nxt.sel = rvx_pkg::SEL_MULW;
      rvx_pkg::CMD_DIVW:   data_nxt.sel = rvx_pkg::SEL_DIVW;
      rvx_pkg::CMD_SLLIW:  alu = rvx_pkg::sext32(operand_a << operand_b[4:0]);
      default:             alu = '0;
    endcase

    // The link address overrides whatever the ALU produced.
    if (link_select) begin
      data_nxt.early = {{(rvx_pkg::XLEN-rvx_pkg::PCW){1'b0}}, pc_word} + 1'b1;
      data_nxt.sel = rvx_pkg::SEL_EARLY;
    end else begin
      data_nxt.early = alu;
    end
    data_nxt.target = pc_word + operand_b[rvx_pkg::PCW-1:0];

    // Sign-magnitude set-up for the shift-add multiplier.
    data_nxt.neg_p = operand_a[rvx_pkg::XLEN-1] ^ operand_b[rvx_pkg::XLEN-1];
    data_nxt.mcand = rvx_pkg::mag(operand_a);
    data_nxt.prod = {{rvx_pkg::XLEN{1'b0}}, rvx_pkg::mag(operand_b)};

    // Sign-magnitude set-up for the restoring divider.
    if (rvx_pkg::cmd_t'(command) == rvx_pkg::CMD_DIVW) begin
      da = rvx_pkg::sext32(operand_a);
      db = rvx_pkg::sext32(operand_b);
    end else begin
      da = operand_a;
      db = operand_b;
    end
    data_nxt.neg_q = da[rvx_pkg::XLEN-1] ^ db[rvx_pkg::XLEN-1];
    data_nxt.neg_r = da[rvx_pkg::XLEN-1];
    data_nxt.div_zero = (db == '0);
    data_nxt.drem = '0;
    data_nxt.dquo = rvx_pkg::mag(da);
    data_nxt.dsor = rvx_pkg::mag(db);
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/rvx_cell.sv @@
// One cell of the chain: a single multiply shift-add step and a single
// restoring divide step per transaction. Depends on rvx_pkg.
`default_nettype none
module rvx_cell (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   valid_in,
  input  rvx_pkg::cell_t data_in,
  output logic        valid_r,
  output rvx_pkg::cell_t data_r
);

  rvx_pkg::cell_t data_nxt;
  logic [rvx_pkg::XLEN:0] msum;
  logic [rvx_pkg::XLEN:0] rsh;
  logic [rvx_pkg::XLEN:0] trial;

  always_comb begin
    data_nxt = data_in;
    // Multiply: add the multiplicand when the current multiplier bit is set.
    msum = {1'b0, data_in.prod[2*rvx_pkg::XLEN-1:rvx_pkg::XLEN]}
         + (data_in.prod[0] ? {1'b0, data_in.mcand} : '0);
    data_nxt.prod = {msum, data_in.prod[rvx_pkg::XLEN-1:1]};
    // Divide: shift in the next dividend bit and try the subtraction.
    rsh = {data_in.drem, data_in.dquo[rvx_pkg::XLEN-1]};
    trial = rsh - {1'b0, data_in.dsor};
    data_nxt.drem = trial[rvx_pkg::XLEN] ? rsh[rvx_pkg::XLEN-1:0]
                                         : trial[rvx_pkg::XLEN-1:0];
    data_nxt.dquo = {data_in.dquo[rvx_pkg::XLEN-2:0], ~trial[rvx_pkg::XLEN]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/rvx_finish.sv @@
// Output stage: applies the sign corrections, selects the result and
// holds the output register. Depends on rvx_pkg.
`default_nettype none
module rvx_finish (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     valid_in,
  input  rvx_pkg::cell_t                data_in,
  output logic                          out_valid,
  output logic [rvx_pkg::XLEN-1:0]      out_result,
  output logic                          out_branch_taken,
  output logic [rvx_pkg::PCW-1:0]       out_branch_target
);

  logic [2*rvx_pkg::XLEN-1:0] prod_s;
  logic [rvx_pkg::XLEN-1:0] quo_s;
  logic [rvx_pkg::XLEN-1:0] rem_s;
  logic [rvx_pkg::XLEN-1:0] res_nxt;

  // Sign correction and result selection.
  always_comb begin
    prod_s = data_in.neg_p ? (~data_in.prod + 1'b1) : data_in.prod;
    if (data_in.div_zero) begin
      quo_s = '1;
    end else begin
      quo_s = data_in.neg_q ? (~data_in.dquo + 1'b1) : data_in.dquo;
    end
    rem_s = data_in.neg_r ? (~data_in.drem + 1'b1) : data_in.drem;
    case (data_in.sel)
      rvx_pkg::SEL_EARLY:  res_nxt = data_in.early;
      rvx_pkg::SEL_MUL_LO: res_nxt = prod_s[rvx_pkg::XLEN-1:0];
      rvx_pkg::SEL_MUL_HI: res_nxt = prod_s[2*rvx_pkg::XLEN-1:rvx_pkg::XLEN];
      rvx_pkg::SEL_MULW:   res_nxt = rvx_pkg::sext32(prod_s[rvx_pkg::XLEN-1:0]);
      rvx_pkg::SEL_DIV:    res_nxt = quo_s;
      rvx_pkg::SEL_REM:    res_nxt = rem_s;
      rvx_pkg::SEL_DIVW:   res_nxt = rvx_pkg::sext32(quo_s);
      default:             res_nxt = data_in.early;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result <= res_nxt;
      out_branch_taken <= data_in.taken;
      out_branch_target <= data_in.target;
    end
  end

endmodule
`default_nettype wire

@@ src/rv64im_execute_alu_top.sv @@
// RV64IM execute stage. A transaction passes through one decode stage loaded at acceptance,
// 64 cells that each retire one multiply bit and one quotient bit, and the output register.
// Throughput is one transaction per cycle; the whole chain holds while a waiting result
// is stalled. Reset (synchronous, active low) clears only the valid bits.
`default_nettype none
module rv64im_execute_alu_top (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [4:0]               in_command,
  input  wire logic [rvx_pkg::XLEN-1:0] in_operand_a,
  input  wire logic [rvx_pkg::XLEN-1:0] in_operand_b,
  input  wire logic [rvx_pkg::XLEN-1:0] in_compare_value,
  input  wire logic [rvx_pkg::PCW-1:0]  in_pc_word,
  input  wire logic                     in_link_select,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [rvx_pkg::XLEN-1:0]      out_result,
  output logic                          out_branch_taken,
  output logic [rvx_pkg::PCW-1:0]       out_branch_target
);

  logic en;
  logic valid_c [0:rvx_pkg::NUM_CELLS];
  rvx_pkg::cell_t data_c [0:rvx_pkg::NUM_CELLS];

  // The chain advances unless a finished result is held back.
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  rvx_prep u_prep (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .command(in_command), .operand_a(in_operand_a), .operand_b(in_operand_b),
    .compare_value(in_compare_value), .pc_word(in_pc_word),
    .link_select(in_link_select), .valid_r(valid_c[0]), .data_r(data_c[0])
  );

  // Chain of identical multiply/divide step cells.
  for (genvar i = 0; i < rvx_pkg::NUM_CELLS; i++) begin : g_cell
    rvx_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_in(valid_c[i]), .data_in(data_c[i]),
      .valid_r(valid_c[i+1]), .data_r(data_c[i+1])
    );
  end

  rvx_finish u_finish (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_in(valid_c[rvx_pkg::NUM_CELLS]), .data_in(data_c[rvx_pkg::NUM_CELLS]),
    .out_valid(out_valid), .out_result(out_result),
    .out_branch_taken(out_branch_taken), .out_branch_target(out_branch_target)
  );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the RV64IM execute stage: directed table, then random transactions.
// Depends on rvx_pkg and rv64im_execute_alu_top; predicts every result itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int XLEN = rvx_pkg::XLEN;
  localparam int PCW = rvx_pkg::PCW;
  localparam int LATENCY = 66;
  localparam int N_RANDOM = 1300;

  typedef struct {
    logic [4:0]      cmd;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] cv;
    logic [PCW-1:0]  pc;
    logic            link;
  } instr_t;

  typedef struct {
    logic [XLEN-1:0] result;
    logic            taken;
    logic [PCW-1:0]  target;
  } outcome_t;

  typedef struct {
    instr_t   ins;
    bit       typed;
    outcome_t want;
  } row_t;

  localparam logic [XLEN-1:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [XLEN-1:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [XLEN-1:0] ONES = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] in_command = '0;
  logic [XLEN-1:0] in_operand_a = '0;
  logic [XLEN-1:0] in_operand_b = '0;
  logic [XLEN-1:0] in_compare_value = '0;
  logic [PCW-1:0] in_pc_word = '0;
  logic in_link_select = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [XLEN-1:0] out_result;
  logic out_branch_taken;
  logic [PCW-1:0] out_branch_target;

  outcome_t expected_q[$];
  int errors = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  always #1 clk = ~clk;

  rv64im_execute_alu_top u_dut (.*);

  // Signed quotient with RISC-V handling of zero divisors and overflow.
  function automatic logic [XLEN-1:0] quotient(logic [XLEN-1:0] a, logic [XLEN-1:0] b);
    logic [XLEN-1:0] q;
    if (b == 0) return ONES;
    q = (a[XLEN-1] ? -a : a) / (b[XLEN-1] ? -b : b);
    return (a[XLEN-1] ^ b[XLEN-1]) ? -q : q;
  endfunction

  function automatic logic [XLEN-1:0] remainder(logic [XLEN-1:0] a, logic [XLEN-1:0] b);
    logic [XLEN-1:0] r;
    if (b == 0) return a;
    r = (a[XLEN-1] ? -a : a) % (b[XLEN-1] ? -b : b);
    return a[XLEN-1] ? -r : r;
  endfunction

  function automatic logic [XLEN-1:0] word_ext(logic [XLEN-1:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Expected outcome of one instruction.
  function automatic outcome_t execute(instr_t i);
    outcome_t o;
    logic [XLEN-1:0] alu;
    logic signed [2*XLEN-1:0] wide;
    logic [5:0] sh;
    alu = '0;
    o.taken = 1'b0;
    sh = i.b[5:0];
    case (i.cmd)
      rvx_pkg::CMD_ADD:    alu = i.a + i.b;
      rvx_pkg::CMD_SUB:    alu = i.a - i.b;
      rvx_pkg::CMD_MUL:    alu = i.a * i.b;
      rvx_pkg::CMD_MULH: begin
        wide = $signed(i.a) * $signed(i.b);
        alu = wide[2*XLEN-1:XLEN];
      end
      rvx_pkg::CMD_DIV:    alu = quotient(i.a, i.b);
      rvx_pkg::CMD_REM:    alu = remainder(i.a, i.b);
      rvx_pkg::CMD_SLL:    alu = i.a << sh;
      rvx_pkg::CMD_SRL:    alu = i.a >> sh;
      rvx_pkg::CMD_SRA:    alu = $signed(i.a) >>> sh;
      rvx_pkg::CMD_AND:    alu = i.a & i.b;
      rvx_pkg::CMD_OR:     alu = i.a | i.b;
      rvx_pkg::CMD_XOR:    alu = i.a ^ i.b;
      rvx_pkg::CMD_SLT:    alu = {63'd0, $signed(i.a) < $signed(i.b)};
      rvx_pkg::CMD_ADDIW, rvx_pkg::CMD_ADDW: alu = word_ext(i.a + i.b);
      rvx_pkg::CMD_BEQ:    o.taken = i.a == i.cv;
      rvx_pkg::CMD_BNE:    o.taken = i.a != i.cv;
      rvx_pkg::CMD_BLT:    o.taken = $signed(i.a) < $signed(i.cv);
      rvx_pkg::CMD_BGE:    o.taken = $signed(i.a) >= $signed(i.cv);
      rvx_pkg::CMD_PASS_A: alu = i.a;
      rvx_pkg::CMD_PASS_B: alu = i.b;
      rvx_pkg::CMD_SUBW:   alu = word_ext(i.a - i.b);
      rvx_pkg::CMD_MULW:   alu = word_ext({32'd0, i.a[31:0]} * {32'd0, i.b[31:0]});
      rvx_pkg::CMD_DIVW:   alu = word_ext(quotient(word_ext(i.a), word_ext(i.b)));
      rvx_pkg::CMD_SLLIW:  alu = word_ext(i.a << i.b[4:0]);
      default:             alu = '0;
    endcase
    o.result = i.link ? {2'b00, i.pc} + 64'd1 : alu;
    o.target = i.pc + i.b[PCW-1:0];
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [XLEN-1:0] rand_operand();
    logic [XLEN-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = MIN64;
      1: v = MAX64;
      2: v = ONES;
      3: v = '0;
      4: v = {{56{v[7]}}, v[7:0]};
      5: v = word_ext(v);
      default: ;
    endcase
    return v;
  endfunction

  task automatic report(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
    errors++;
    $display("%t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Drive one transaction and hold it until it is accepted.
  task automatic send(instr_t i);
    in_valid <= 1'b1;
    in_command <= i.cmd;
    in_operand_a <= i.a;
    in_operand_b <= i.b;
    in_compare_value <= i.cv;
    in_pc_word <= i.pc;
    in_link_select <= i.link;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // A gap of zero leaves valid alone, so the next transaction follows directly.
  task automatic idle(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Prediction is made at acceptance.
  always @(posedge clk) begin
    instr_t acc;
    if (rst_n && in_valid && !in_stall) begin
      acc.cmd = in_command;
      acc.a = in_operand_a;
      acc.b = in_operand_b;
      acc.cv = in_compare_value;
      acc.pc = in_pc_word;
      acc.link = in_link_select;
      expected_q.push_back(execute(acc));
    end
  end

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", out_result, '0);
      end else begin
        w = expected_q.pop_front();
        if (out_result !== w.result) report("result", out_result, w.result);
        if (out_branch_taken !== w.taken)
          report("branch_taken", {63'd0, out_branch_taken}, {63'd0, w.taken});
        if (out_branch_target !== w.target)
          report("branch_target", {2'b00, out_branch_target}, {2'b00, w.target});
      end
    end
  end

  // Receiver stalls, with one long hold-off requested by the sender.
  always @(negedge clk) begin
    int hold;
    if (long_hold) begin
      out_stall <= 1'b1;
      for (hold = 0; hold < 150; hold++) @(negedge clk);
      long_hold = 1'b0;
      out_stall <= 1'b0;
    end else if (stim_done || $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= gap_len() > 0;
    end
  end

  // Directed table, then random transactions.
  initial begin
    row_t rows[$];
    row_t r;
    instr_t ins;
    outcome_t pred;
    int k;
    int wait_n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    r.typed = 1'b1;
    r.ins = '{rvx_pkg::CMD_ADD, MAX64, 64'd1, '0, '0, 1'b0};
    r.want = '{MIN64, 1'b0, 62'd1}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_DIV, 64'd7, '0, '0, '0, 1'b0};
    r.want = '{ONES, 1'b0, '0}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_REM, 64'd7, '0, '0, '0, 1'b0};
    r.want = '{64'd7, 1'b0, '0}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_DIV, MIN64, ONES, '0, '0, 1'b0};
    r.want = '{MIN64, 1'b0, '1}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_REM, MIN64, ONES, '0, '0, 1'b0};
    r.want = '{'0, 1'b0, '1}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_DIVW, 64'h8000_0000, 64'hffff_ffff, '0, '0, 1'b0};
    r.want = '{64'hffff_ffff_8000_0000, 1'b0, 62'hffff_ffff}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_DIVW, 64'd5, 64'h1_0000_0000, '0, '0, 1'b0};
    r.want = '{ONES, 1'b0, 62'h1_0000_0000}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_BEQ, 64'd3, 64'd4, 64'd3, '1, 1'b0};
    r.want = '{'0, 1'b1, 62'd3}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_BLT, MIN64, '0, MAX64, 62'd10, 1'b1};
    r.want = '{64'd11, 1'b1, 62'd10}; rows.push_back(r);
    r.ins = '{5'd31, ONES, ONES, ONES, '0, 1'b0};
    r.want = '{'0, 1'b0, '1}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_SLL, 64'd1, 64'd127, '0, '0, 1'b0};
    r.want = '{MIN64, 1'b0, 62'd127}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_PASS_A, ONES, '0, '0, '1, 1'b1};
    r.want = '{64'h4000_0000_0000_0000, 1'b0, '1}; rows.push_back(r);
    r.typed = 1'b0;
    for (k = rvx_pkg::CMD_MULH; k <= 25; k++) begin
      r.ins = '{k[4:0], rand_operand(), rand_operand(), rand_operand(),
                PCW'({$urandom, $urandom}), 1'b0};
      rows.push_back(r);
    end
    r.ins = '{rvx_pkg::CMD_SRA, MIN64, 64'd63, '0, '0, 1'b0}; rows.push_back(r);
    r.ins = '{rvx_pkg::CMD_SLLIW, 64'h1, 64'd63, '0, '0, 1'b0}; rows.push_back(r);

    foreach (rows[n]) begin
      if (rows[n].typed) begin
        pred = execute(rows[n].ins);
        if (pred.result !== rows[n].want.result || pred.taken !== rows[n].want.taken ||
            pred.target !== rows[n].want.target)
          report("directed row", pred.result, rows[n].want.result);
      end
      send(rows[n].ins);
      idle(gap_len());
    end

    for (k = 0; k < N_RANDOM; k++) begin
      // Long receiver hold-off while the sender keeps offering.
      if (k == 300) long_hold = 1'b1;
      // Sender pause until the pipeline has drained.
      if (k == 700) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_q.size() != 0);
      end
      ins.cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(25, 31))
                                             : 5'($urandom_range(0, 24));
      ins.a = rand_operand();
      ins.b = rand_operand();
      ins.cv = ($urandom_range(0, 2) == 0) ? ins.a : rand_operand();
      ins.pc = PCW'({$urandom, $urandom});
      ins.link = $urandom_range(0, 7) == 0;
      send(ins);
      if (k < 250 || k > 400) idle(gap_len());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (expected_q.size() != 0) @(negedge clk);
    for (wait_n = 0; wait_n < LATENCY + 10; wait_n++) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end
endmodule

@@ rv64im_execute_alu_top.f @@
src/rvx_pkg.sv
src/rvx_prep.sv
src/rvx_cell.sv
src/rvx_finish.sv
src/rv64im_execute_alu_top.sv
verif/tb.sv
